// File: sv/min_jerk_trajectory_generator_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef MIN_JERK_TRAJECTORY_GENERATOR_UNIT_DEFINES_SVH
`define MIN_JERK_TRAJECTORY_GENERATOR_UNIT_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define MJT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define MJT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mjt_pkg.sv
// Types, constants and arithmetic helpers of the minimum-jerk trajectory generator.
package mjt_pkg;

  localparam int unsigned DurW      = 12;
  localparam logic [DurW-1:0] DurReset = 12'd200;
  localparam int unsigned DataW     = 32;
  localparam int unsigned CoefW     = 48;
  localparam int unsigned FracW     = 24;
  localparam int unsigned PowW      = 25;
  localparam int unsigned NumCoef   = 6;
  localparam int unsigned NumTerms  = 15;
  localparam int unsigned OutAxes   = 3;
  localparam int unsigned AccW      = 56;
  localparam int unsigned DivNW     = 56;
  localparam int unsigned DivDW     = 24;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned C2W       = 60;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncTick = 1'b1;

  localparam logic signed [C2W-1:0] C48Max = 60'sd140737488355327;
  localparam logic signed [C2W-1:0] C48Min = -60'sd140737488355328;
  localparam logic signed [56:0]    S32Max = 57'sd2147483647;
  localparam logic signed [56:0]    S32Min = -57'sd2147483648;

  typedef enum logic {CMD_LOAD, CMD_TICK} cmd_e;
  typedef enum logic [1:0] {DST_POS, DST_VEL, DST_ACC} dst_e;

  typedef enum logic [3:0] {
    B_IDLE, B_LD_MUL, B_LD_SQ, B_LD_COEF, B_TAU_GO, B_TAU_WAIT, B_POW,
    B_MUL, B_ACC, B_VDIV_GO, B_VDIV_WAIT, B_ADIV_GO, B_ADIV_WAIT, B_OUT
  } back_state_e;

  typedef struct packed {
    logic              func;
    logic [1:0]        axis;
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] target_pos;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic               last;
  } out_t;

  typedef struct packed {
    cmd_e               kind;
    logic [1:0]         axis;
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] target_pos;
    logic [DurW-1:0]    index;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivNW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [2:0] coef;
    logic [2:0] pw;
    logic [4:0] weight;
    dst_e       dst;
  } term_t;

  // Product terms of position, velocity and acceleration sums.
  function automatic term_t term_info(input logic [3:0] j);
    term_t t;
    case (j)
      4'd0:  t = '{coef: 3'd0, pw: 3'd0, weight: 5'd1,  dst: DST_POS};
      4'd1:  t = '{coef: 3'd1, pw: 3'd1, weight: 5'd1,  dst: DST_POS};
      4'd2:  t = '{coef: 3'd2, pw: 3'd2, weight: 5'd1,  dst: DST_POS};
      4'd3:  t = '{coef: 3'd3, pw: 3'd3, weight: 5'd1,  dst: DST_POS};
      4'd4:  t = '{coef: 3'd4, pw: 3'd4, weight: 5'd1,  dst: DST_POS};
      4'd5:  t = '{coef: 3'd5, pw: 3'd5, weight: 5'd1,  dst: DST_POS};
      4'd6:  t = '{coef: 3'd1, pw: 3'd0, weight: 5'd1,  dst: DST_VEL};
      4'd7:  t = '{coef: 3'd2, pw: 3'd1, weight: 5'd2,  dst: DST_VEL};
      4'd8:  t = '{coef: 3'd3, pw: 3'd2, weight: 5'd3,  dst: DST_VEL};
      4'd9:  t = '{coef: 3'd4, pw: 3'd3, weight: 5'd4,  dst: DST_VEL};
      4'd10: t = '{coef: 3'd5, pw: 3'd4, weight: 5'd5,  dst: DST_VEL};
      4'd11: t = '{coef: 3'd2, pw: 3'd0, weight: 5'd2,  dst: DST_ACC};
      4'd12: t = '{coef: 3'd3, pw: 3'd1, weight: 5'd6,  dst: DST_ACC};
      4'd13: t = '{coef: 3'd4, pw: 3'd2, weight: 5'd12, dst: DST_ACC};
      4'd14: t = '{coef: 3'd5, pw: 3'd3, weight: 5'd20, dst: DST_ACC};
      default: t = '{coef: 3'd0, pw: 3'd0, weight: 5'd0, dst: DST_POS};
    endcase
    return t;
  endfunction

  // One coefficient: doubled form, halved toward zero, clipped to 48 bits.
  function automatic logic signed [CoefW-1:0] coef_calc(
    input logic [2:0]         k,
    input logic signed [31:0] p,
    input logic signed [44:0] vt,
    input logic signed [56:0] at2,
    input logic signed [32:0] d
  );
    logic signed [C2W-1:0] pe, ve, ae, de, c2, ch;
    pe = C2W'(p);
    ve = C2W'(vt);
    ae = C2W'(at2);
    de = C2W'(d);
    case (k)
      3'd0: c2 = pe <<< 1;
      3'd1: c2 = ve <<< 1;
      3'd2: c2 = ae;
      3'd3: c2 = de * 20 - ve * 12 - ae * 3;
      3'd4: c2 = ve * 16 + ae * 3 - de * 30;
      3'd5: c2 = de * 12 - ve * 6 - ae;
      default: c2 = '0;
    endcase
    ch = (c2 + $signed({{(C2W-1){1'b0}}, c2[C2W-1]})) >>> 1;
    if (ch > C48Max) return C48Max[CoefW-1:0];
    if (ch < C48Min) return C48Min[CoefW-1:0];
    return ch[CoefW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [56:0] v);
    if (v > S32Max) return S32Max[DataW-1:0];
    if (v < S32Min) return S32Min[DataW-1:0];
    return v[DataW-1:0];
  endfunction

endpackage

// File: sv/mjt_in_if.sv
// Input channel: valid/ready handshake carrying one input item.
interface mjt_in_if import mjt_pkg::*; ();
  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/mjt_out_if.sv
// Output channel: valid/ready handshake carrying one waypoint.
interface mjt_out_if import mjt_pkg::*; ();
  logic valid;
  logic ready;
  out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/mjt_fifo.sv
// Short command queue between the front and back parts.
module mjt_fifo import mjt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  cmd_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// File: sv/mjt_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module mjt_div import mjt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DivNW);

  logic [DivDW-1:0] rem_q;
  logic [DivNW-1:0] quo_q;
  logic [DivDW-1:0] dsr_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DivDW+1:0] diff;

  assign diff = {1'b0, rem_q, quo_q[DivNW-1]} - {2'b0, dsr_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivNW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      // no borrow: the divisor fits, take the difference
      if (!diff[DivDW+1]) begin
        rem_q <= diff[DivDW-1:0];
        quo_q <= {quo_q[DivNW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DivDW-2:0], quo_q[DivNW-1]};
        quo_q <= {quo_q[DivNW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: sv/mjt_front.sv
// Front part: accepts items, drops idle ticks and bad loads, tracks the segment.
module mjt_front import mjt_pkg::*; #(
  parameter int unsigned NUM_AXES = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DurW-1:0] dur_i,
  mjt_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic            running_q, running_d;
  logic [DurW-1:0] index_q, index_d;
  logic            xfer, is_last;

  assign in_i.ready = !full_i;
  assign xfer       = in_i.valid && in_i.ready;
  assign is_last    = ({1'b0, index_q} + 1'b1) >= {1'b0, dur_i};

  always_comb begin
    running_d        = running_q;
    index_d          = index_q;
    push_o           = 1'b0;
    cmd_o.kind       = CMD_LOAD;
    cmd_o.axis       = in_i.payload.axis;
    cmd_o.start_pos  = in_i.payload.start_pos;
    cmd_o.start_vel  = in_i.payload.start_vel;
    cmd_o.start_acc  = in_i.payload.start_acc;
    cmd_o.target_pos = in_i.payload.target_pos;
    cmd_o.index      = index_q;
    cmd_o.last       = 1'b0;
    if (xfer) begin
      if (in_i.payload.func == FuncLoad) begin
        if (32'(in_i.payload.axis) < NUM_AXES) begin
          push_o    = 1'b1;
          running_d = 1'b1;
          index_d   = '0;
        end
      end else if (running_q) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_TICK;
        cmd_o.last = is_last;
        if (is_last) begin
          running_d = 1'b0;
        end else begin
          index_d = index_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      index_q   <= '0;
    end else begin
      running_q <= running_d;
      index_q   <= index_d;
    end
  end

endmodule

// File: sv/mjt_back.sv
// Back part: coefficient solve on loads, polynomial evaluation on ticks.
module mjt_back import mjt_pkg::*; #(
  parameter int unsigned NUM_AXES = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DurW-1:0] dur_i,
  input  logic            empty_i,
  input  cmd_t            cmd_i,
  output logic            pop_o,
  output div_req_t        div_req_o,
  input  div_rsp_t        div_rsp_i,
  mjt_out_if.source       out_o
);

  localparam int unsigned AxW    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int unsigned NumOut = (NUM_AXES < OutAxes) ? NUM_AXES : OutAxes;

  back_state_e state_q, state_d;

  logic signed [CoefW-1:0] coef_q [NUM_AXES][NumCoef];
  logic [PowW-1:0]         pw_q [NumCoef];
  logic [PowW-1:0]         prev_q;
  cmd_t                    cmd_q;
  logic [2*DurW-1:0]       tsq_q;
  logic signed [44:0]      vt_q;
  logic signed [56:0]      at2_q;
  logic signed [32:0]      d_q;
  logic [2:0]              k_q;
  logic [1:0]              a_q;
  logic [3:0]              j_q;
  logic signed [49:0]      ph_q;
  logic [48:0]             pl_q;
  logic signed [AccW-1:0]  ps_q, vs_q, as_q;
  logic                    neg_q;
  logic signed [DataW-1:0] pos_r_q [OutAxes];
  logic signed [DataW-1:0] vel_r_q [OutAxes];
  logic signed [DataW-1:0] acc_r_q [OutAxes];
  logic                    out_valid_q;
  out_t                    out_data_q, out_data_d;

  term_t                   term;
  logic signed [CoefW-1:0] c_sel;
  logic [PowW-1:0]         p_sel;
  logic signed [49:0]      q_sum;
  logic signed [AccW-1:0]  wq;
  logic [2*PowW-1:0]       pw_prod;
  logic [DurW-1:0]         idx_clamp;
  logic [AccW-1:0]         vs_abs, as_abs;
  logic signed [56:0]      quo_s;
  logic                    out_free;
  logic signed [DataW-1:0] pos_v [OutAxes];
  logic signed [DataW-1:0] vel_v [OutAxes];
  logic signed [DataW-1:0] acc_v [OutAxes];

  assign term      = term_info(j_q);
  assign c_sel     = coef_q[AxW'(a_q)][term.coef];
  assign p_sel     = pw_q[term.pw];
  // floor(c * p / 2^24) split into high and low coefficient halves
  assign q_sum     = ph_q + $signed({1'b0, pl_q[48:FracW]});
  assign wq        = q_sum * $signed({1'b0, term.weight});
  assign pw_prod   = prev_q * pw_q[1];
  assign idx_clamp = (cmd_q.index > dur_i) ? dur_i : cmd_q.index;
  assign vs_abs    = vs_q[AccW-1] ? -vs_q : vs_q;
  assign as_abs    = as_q[AccW-1] ? -as_q : as_q;
  assign quo_s     = neg_q ? -$signed({1'b0, div_rsp_i.quotient})
                           : $signed({1'b0, div_rsp_i.quotient});
  assign out_free  = !out_valid_q || out_o.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          state_d = (cmd_i.kind == CMD_LOAD) ? B_LD_MUL : B_TAU_GO;
        end
      end
      B_LD_MUL:  state_d = B_LD_SQ;
      B_LD_SQ:   state_d = B_LD_COEF;
      B_LD_COEF: begin
        if (k_q == 3'(NumCoef - 1)) state_d = B_IDLE;
      end
      B_TAU_GO:   state_d = B_TAU_WAIT;
      B_TAU_WAIT: begin
        if (div_rsp_i.done) state_d = B_POW;
      end
      B_POW: begin
        if (k_q == 3'(NumCoef - 1)) state_d = B_MUL;
      end
      B_MUL: state_d = B_ACC;
      B_ACC: begin
        state_d = (j_q == 4'(NumTerms - 1)) ? B_VDIV_GO : B_MUL;
      end
      B_VDIV_GO:   state_d = B_VDIV_WAIT;
      B_VDIV_WAIT: begin
        if (div_rsp_i.done) state_d = B_ADIV_GO;
      end
      B_ADIV_GO:   state_d = B_ADIV_WAIT;
      B_ADIV_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = (a_q == 2'(NumOut - 1)) ? B_OUT : B_MUL;
        end
      end
      B_OUT: begin
        if (out_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o             = 1'b0;
    div_req_o         = '0;
    div_req_o.divisor = DivDW'(dur_i);
    unique case (state_q)
      B_IDLE: pop_o = !empty_i;
      B_TAU_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DivNW'({idx_clamp, {FracW{1'b0}}});
      end
      B_VDIV_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = vs_abs;
      end
      B_ADIV_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = as_abs;
        div_req_o.divisor  = tsq_q;
      end
      default: ;
    endcase
  end

  // axes the block does not have read as zero
  always_comb begin
    for (int i = 0; i < OutAxes; i++) begin
      pos_v[i] = (i < NumOut) ? pos_r_q[i] : '0;
      vel_v[i] = (i < NumOut) ? vel_r_q[i] : '0;
      acc_v[i] = (i < NumOut) ? acc_r_q[i] : '0;
    end
    out_data_d.pos_x = pos_v[0];
    out_data_d.pos_y = pos_v[1];
    out_data_d.pos_z = pos_v[2];
    out_data_d.vel_x = vel_v[0];
    out_data_d.vel_y = vel_v[1];
    out_data_d.vel_z = vel_v[2];
    out_data_d.acc_x = acc_v[0];
    out_data_d.acc_y = acc_v[1];
    out_data_d.acc_z = acc_v[2];
    out_data_d.last  = cmd_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      a_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE:      k_q <= '0;
        B_LD_COEF:   k_q <= k_q + 1'b1;
        B_TAU_WAIT:  k_q <= 3'd2;
        B_POW: begin
          k_q <= k_q + 1'b1;
          a_q <= '0;
          j_q <= '0;
        end
        B_ACC:       j_q <= j_q + 1'b1;
        B_ADIV_WAIT: begin
          if (div_rsp_i.done) begin
            a_q <= a_q + 1'b1;
            j_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int k = 0; k < NumCoef; k++) begin
          coef_q[a][k] <= '0;
        end
      end
    end else if (state_q == B_LD_COEF) begin
      coef_q[AxW'(cmd_q.axis)][k_q] <=
        coef_calc(k_q, cmd_q.start_pos, vt_q, at2_q, d_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_OUT && out_free) begin
      out_data_q <= out_data_d;
    end
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) cmd_q <= cmd_i;
      end
      B_LD_MUL: begin
        vt_q  <= $signed(cmd_q.start_vel) * $signed({1'b0, dur_i});
        tsq_q <= dur_i * dur_i;
        d_q   <= 33'(cmd_q.target_pos) - 33'(cmd_q.start_pos);
      end
      B_LD_SQ: at2_q <= $signed(cmd_q.start_acc) * $signed({1'b0, tsq_q});
      B_TAU_GO: tsq_q <= dur_i * dur_i;
      B_TAU_WAIT: begin
        if (div_rsp_i.done) begin
          pw_q[0] <= PowW'(1) << FracW;
          pw_q[1] <= div_rsp_i.quotient[PowW-1:0];
          prev_q  <= div_rsp_i.quotient[PowW-1:0];
        end
      end
      B_POW: begin
        pw_q[k_q] <= pw_prod[FracW+PowW-1:FracW];
        prev_q    <= pw_prod[FracW+PowW-1:FracW];
        ps_q      <= '0;
        vs_q      <= '0;
        as_q      <= '0;
      end
      B_MUL: begin
        ph_q <= $signed(c_sel[CoefW-1:FracW]) * $signed({1'b0, p_sel});
        pl_q <= c_sel[FracW-1:0] * p_sel;
      end
      B_ACC: begin
        case (term.dst)
          DST_POS: ps_q <= ps_q + wq;
          DST_VEL: vs_q <= vs_q + wq;
          default: as_q <= as_q + wq;
        endcase
      end
      B_VDIV_GO: begin
        pos_r_q[a_q] <= sat32(57'(ps_q));
        neg_q        <= vs_q[AccW-1];
      end
      B_VDIV_WAIT: begin
        if (div_rsp_i.done) vel_r_q[a_q] <= sat32(quo_s);
      end
      B_ADIV_GO: neg_q <= as_q[AccW-1];
      B_ADIV_WAIT: begin
        if (div_rsp_i.done) begin
          acc_r_q[a_q] <= sat32(quo_s);
          ps_q         <= '0;
          vs_q         <= '0;
          as_q         <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/min_jerk_trajectory_generator_unit.sv
// Load: from queue pop to the last coefficient write, two multiplies then six writes.
// Tick: from queue pop to the waypoint register, using the shared 56-step divider: the
//   pop, the tau division, the powers, per axis the 15 product terms and the velocity and
//   acceleration divisions, then the load of the output register.
// One item at a time in the back part; a 2-entry queue keeps the input open meanwhile.
// Reset: coefficients, sample index and run flag clear at once, duration returns to 200.
module min_jerk_trajectory_generator_unit import mjt_pkg::*; #(
  parameter int unsigned NUM_AXES     = 3,
  parameter int unsigned MAX_DURATION = 4095
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            duration_we_i,
  input  logic [DurW-1:0] duration_wdata_i,
  mjt_in_if.sink          in_i,
  mjt_out_if.source       out_o
);

  logic [DurW-1:0] dur_q, dur_eff;
  logic            push, full, pop, empty;
  cmd_t            push_cmd, pop_cmd;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  // port views for the bound checker
  logic in_valid, in_ready, in_func, out_valid, out_ready;
  out_t out_data;

  assign in_valid  = in_i.valid;
  assign in_ready  = in_i.ready;
  assign in_func   = in_i.payload.func;
  assign out_valid = out_o.valid;
  assign out_ready = out_o.ready;
  assign out_data  = out_o.payload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DurReset;
    end else if (duration_we_i) begin
      dur_q <= duration_wdata_i;
    end
  end

  always_comb begin
    if (dur_q == '0) begin
      dur_eff = DurW'(1);
    end else if (32'(dur_q) > MAX_DURATION) begin
      dur_eff = DurW'(MAX_DURATION);
    end else begin
      dur_eff = dur_q;
    end
  end

  mjt_front #(.NUM_AXES(NUM_AXES)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dur_i  (dur_eff),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  mjt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .empty_o (empty)
  );

  mjt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  mjt_back #(.NUM_AXES(NUM_AXES)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dur_i     (dur_eff),
    .empty_i   (empty),
    .cmd_i     (pop_cmd),
    .pop_o     (pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .out_o     (out_o)
  );

endmodule

// File: sv/mjt_checker.sv
// Port-level checks of the trajectory generator, bound to the top level.
`include "min_jerk_trajectory_generator_unit_defines.svh"

module mjt_checker import mjt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_func_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input out_t out_data_i
);

  logic tick_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_seen_q <= 1'b0;
    end else if (in_valid_i && in_ready_i && in_func_i == FuncTick) begin
      tick_seen_q <= 1'b1;
    end
  end

  `MJT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled waypoint changed")
  `MJT_ASSERT_NOW(a_out_needs_tick, out_valid_i, tick_seen_q, "waypoint without a tick transfer")
  `MJT_ASSERT_NOW(a_out_known, out_valid_i, !$isunknown(out_data_i), "waypoint has unknown bits")

endmodule

bind min_jerk_trajectory_generator_unit mjt_checker u_mjt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid),
  .in_ready_i  (in_ready),
  .in_func_i   (in_func),
  .out_valid_i (out_valid),
  .out_ready_i (out_ready),
  .out_data_i  (out_data)
);

// File: test/tb.sv
// Self-checking bench for the min-jerk trajectory generator: directed table, then random traffic.
module tb;
  import mjt_pkg::*;

  localparam longint OneQ = 64'sd16777216;
  localparam int WdogLimit = 12000;
  localparam int SettleCyc = 700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic duration_we_i = 1'b0;
  logic [DurW-1:0] duration_wdata_i = '0;

  mjt_in_if in_if ();
  mjt_out_if out_if ();

  min_jerk_trajectory_generator_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .duration_we_i(duration_we_i), .duration_wdata_i(duration_wdata_i),
    .in_i(in_if), .out_o(out_if)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
  end

  // predictor state
  longint coef_m[3][6];
  int unsigned seg_idx;
  bit seg_run;
  logic [DurW-1:0] dur_m;

  out_t waypoint_q[$];
  int errs = 0;
  int sidle = 0, ridle = 0;
  bit hold_req = 1'b0;
  bit typed_on = 1'b0;
  out_t typed_wp;
  int idle_cyc = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor(c * p / 2^24)
  function automatic longint qmul(longint c, longint p);
    longint lo, hi;
    lo = c & 64'hFFFFFF;
    hi = (c - lo) / OneQ;
    return hi * p + ((lo * p) >>> 24);
  endfunction

  task automatic predict(input in_t it, output bit got, output out_t wp);
    longint t, p, vt, at2, d, idx, tau, ps, vs, as_sum;
    longint c2[6];
    longint pw[6];
    logic [31:0] o[9];
    t = (dur_m == 0) ? 1 : longint'(dur_m);
    got = 1'b0;
    wp = '0;
    if (it.func == FuncLoad) begin
      if (it.axis < 2'd3) begin
        p = longint'(it.start_pos);
        vt = longint'(it.start_vel) * t;
        at2 = longint'(it.start_acc) * t * t;
        d = longint'(it.target_pos) - p;
        c2[0] = 2 * p;
        c2[1] = 2 * vt;
        c2[2] = at2;
        c2[3] = 20 * d - 12 * vt - 3 * at2;
        c2[4] = -30 * d + 16 * vt + 3 * at2;
        c2[5] = 12 * d - 6 * vt - at2;
        for (int k = 0; k < 6; k++)
          coef_m[it.axis][k] = clip(c2[k] / 2, -64'sd140737488355328, 64'sd140737488355327);
        seg_idx = 0;
        seg_run = 1'b1;
      end
    end else if (seg_run) begin
      idx = longint'(seg_idx);
      if (idx > t) idx = t;
      tau = (idx << 24) / t;
      pw[0] = OneQ;
      for (int k = 1; k < 6; k++) pw[k] = (pw[k-1] * tau) >> 24;
      for (int a = 0; a < 3; a++) begin
        ps = 0; vs = 0; as_sum = 0;
        for (int k = 0; k < 6; k++) ps += qmul(coef_m[a][k], pw[k]);
        for (int k = 1; k < 6; k++) vs += k * qmul(coef_m[a][k], pw[k-1]);
        for (int k = 2; k < 6; k++) as_sum += (k * (k - 1)) * qmul(coef_m[a][k], pw[k-2]);
        o[a] = 32'(clip(ps, -64'sd2147483648, 64'sd2147483647));
        o[3+a] = 32'(clip(vs / t, -64'sd2147483648, 64'sd2147483647));
        o[6+a] = 32'(clip(as_sum / (t * t), -64'sd2147483648, 64'sd2147483647));
      end
      wp = '{pos_x: o[0], pos_y: o[1], pos_z: o[2], vel_x: o[3], vel_y: o[4],
             vel_z: o[5], acc_x: o[6], acc_y: o[7], acc_z: o[8], last: 1'b0};
      wp.last = (longint'(seg_idx) + 1 >= t);
      if (wp.last) seg_run = 1'b0;
      else seg_idx = (seg_idx + 1) & 12'hFFF;
      got = 1'b1;
    end
  endtask

  // input side and register writes, in transfer order
  always @(posedge clk_i or negedge rst_ni) begin
    bit got;
    out_t wp;
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) for (int k = 0; k < 6; k++) coef_m[a][k] = 0;
      seg_idx = 0;
      seg_run = 1'b0;
      dur_m = DurReset;
    end else begin
      if (duration_we_i) dur_m = duration_wdata_i;
      if (in_if.valid && in_if.ready) begin
        predict(in_if.payload, got, wp);
        if (got) waypoint_q.insert(waypoint_q.size(), typed_on ? typed_wp : wp);
        typed_on = 1'b0;
      end
    end
  end

  task automatic chk(string n, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", n, e, a);
      errs++;
    end
  endtask

  always @(posedge clk_i) begin
    out_t e, a;
    if (rst_ni && out_if.valid && out_if.ready) begin
      a = out_if.payload;
      if (waypoint_q.size() == 0) begin
        $error("waypoint with none expected");
        errs++;
      end else begin
        e = waypoint_q.pop_front();
        chk("pos_x", e.pos_x, a.pos_x);
        chk("pos_y", e.pos_y, a.pos_y);
        chk("pos_z", e.pos_z, a.pos_z);
        chk("vel_x", e.vel_x, a.vel_x);
        chk("vel_y", e.vel_y, a.vel_y);
        chk("vel_z", e.vel_z, a.vel_z);
        chk("acc_x", e.acc_x, a.acc_x);
        chk("acc_y", e.acc_y, a.acc_y);
        chk("acc_z", e.acc_z, a.acc_z);
        chk("last", 32'(e.last), 32'(a.last));
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    int hold_cnt;
    if (hold_req) begin
      hold_cnt = 3000;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) hold_cnt--;
    out_if.ready <= rst_ni && (hold_cnt == 0) && ($urandom_range(0, 99) >= ridle);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= WdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(input in_t it);
    if ($urandom_range(0, 99) < sidle) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sidle);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic cfg_write(input logic [DurW-1:0] v);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (waypoint_q.size() == 0);
    repeat (SettleCyc) @(posedge clk_i);
    duration_we_i <= 1'b1;
    duration_wdata_i <= v;
    @(posedge clk_i);
    duration_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rval();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4, 5: return $urandom();
      default: return $signed($urandom()) >>> $urandom_range(6, 14);
    endcase
  endfunction

  function automatic in_t ld(logic [1:0] ax, logic [31:0] p, logic [31:0] v,
                             logic [31:0] a, logic [31:0] tg);
    return '{func: FuncLoad, axis: ax, start_pos: p, start_vel: v, start_acc: a,
             target_pos: tg};
  endfunction

  function automatic in_t tk();
    return '{func: FuncTick, axis: 2'($urandom()), start_pos: $urandom(),
             start_vel: $urandom(), start_acc: $urandom(), target_pos: $urandom()};
  endfunction

  typedef struct {
    bit wr;
    logic [DurW-1:0] dur;
    in_t it;
    bit typed;
    out_t wp;
  } row_t;

  function automatic row_t r_in(in_t it);
    return '{wr: 1'b0, dur: '0, it: it, typed: 1'b0, wp: '0};
  endfunction

  function automatic row_t r_cfg(logic [DurW-1:0] d);
    return '{wr: 1'b1, dur: d, it: '0, typed: 1'b0, wp: '0};
  endfunction

  function automatic row_t r_exp(out_t wp);
    return '{wr: 1'b0, dur: '0, it: tk(), typed: 1'b1, wp: wp};
  endfunction

  task automatic run_phase(logic [DurW-1:0] d, int s, int r, bit press, int n);
    int cnt, te, nt, sel;
    cfg_write(d);
    sidle = s;
    ridle = r;
    if (press) hold_req = 1'b1;
    te = (d == 0) ? 1 : int'(d);
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        repeat ($urandom_range(1, 3)) begin
          send(ld(2'($urandom_range(0, 2)), rval(), rval(), rval(), rval()));
          cnt++;
        end
        nt = (te > 40) ? $urandom_range(5, 40) : te + $urandom_range(0, 2);
        repeat (nt) begin
          send(tk());
          cnt++;
        end
      end else begin
        case (sel % 4)
          0: send(ld(2'd3, rval(), rval(), rval(), rval()));
          1: begin send(tk()); cnt++; end
          2: begin send(ld(2'($urandom_range(0, 2)), rval(), rval(), rval(), rval())); cnt++; end
          default: begin send(ld(2'($urandom()), $urandom(), $urandom(), $urandom(),
                                  $urandom()) ^ {1'($urandom()), 130'b0}); cnt++; end
        endcase
      end
    end
  endtask

  row_t dir_tab[$];

  initial begin
    dir_tab = '{
      r_in(tk()),
      r_in(ld(2'd3, 32'h7FFF_FFFF, 32'h1, 32'h1, 32'h8000_0000)),
      r_in(tk()),
      r_cfg(12'd1),
      r_in(ld(2'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF)),
      r_exp('{pos_x: 32'h7FFF_FFFF, last: 1'b1, default: '0}),
      r_in(ld(2'd1, 32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000)),
      r_exp('{pos_x: 32'h7FFF_FFFF, pos_y: 32'h8000_0000, last: 1'b1, default: '0}),
      r_in(tk()),
      r_in(ld(2'd2, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0)),
      r_in(tk()),
      r_cfg(12'd0),
      r_in(ld(2'd0, 32'h0, 32'h0, 32'h0, 32'h0100_0000)),
      r_in(tk()),
      r_cfg(12'd4095),
      r_in(ld(2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF)),
      r_in(tk()),
      r_in(tk()),
      r_cfg(12'd5),
      r_in(ld(2'd1, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF)),
      r_in(tk()),
      r_in(tk()),
      r_in(ld(2'd3, 32'h0, 32'h0, 32'h0, 32'h0)),
      r_in(ld(2'd2, 32'hFF00_0000, 32'h0001_0000, 32'hFFFF_F000, 32'h0200_0000)),
      r_in(tk()), r_in(tk()), r_in(tk()), r_in(tk()), r_in(tk()), r_in(tk())
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) cfg_write(dir_tab[i].dur);
      else begin
        typed_on = dir_tab[i].typed;
        typed_wp = dir_tab[i].wp;
        send(dir_tab[i].it);
      end
    end

    run_phase(12'd2, 33, 80, 1'b0, 200);
    run_phase(12'd0, 33, 80, 1'b0, 200);
    run_phase(12'd13, 33, 80, 1'b0, 200);
    run_phase(12'd1, 80, 33, 1'b0, 200);
    run_phase(12'd4095, 80, 33, 1'b0, 200);
    run_phase(12'd37, 80, 33, 1'b0, 200);
    run_phase(12'($urandom_range(1, 20)), 0, 0, 1'b1, 200);
    run_phase(12'd3, 0, 0, 1'b0, 200);

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (waypoint_q.size() == 0);
    repeat (SettleCyc) @(posedge clk_i);
    if (errs == 0 && waypoint_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
